/* rtl/core/wwpc_pkg.sv */
// ----------------------------------------------------------------------------
// wwpc_pkg
// Shared types, constants and character helpers for the whole-word censor.
// ----------------------------------------------------------------------------
package wwpc_pkg;

    localparam int PATTERN_MAX_DEFAULT = 8;

    localparam int BYTE_W     = 8;
    localparam int PAT_W      = 64;
    localparam int LEN_W      = 4;
    localparam int CFG_ADDR_W = 1;

    localparam logic [BYTE_W-1:0] STAR_CHAR     = 8'h2A;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_A  = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_Z  = 8'h5A;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_A  = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_Z  = 8'h7A;
    localparam logic [BYTE_W-1:0] CHAR_DIGIT_0  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_DIGIT_9  = 8'h39;
    localparam logic [BYTE_W-1:0] CASE_OFFSET   = 8'd32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PATTERN_CHARS = 1'b0,
        REG_PATTERN_LEN   = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic advance;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic last;
        logic out_free;
    } dp_status_t;

    function automatic logic is_alnum(input logic [BYTE_W-1:0] c);
        return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
               ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ||
               ((c >= CHAR_DIGIT_0) && (c <= CHAR_DIGIT_9));
    endfunction

    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
        return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ? c + CASE_OFFSET : c;
    endfunction

endpackage

/* rtl/core/wwpc_datapath.sv */
// ----------------------------------------------------------------------------
// wwpc_datapath
// Match state, held bytes, flush buffer, configuration and output register.
// ----------------------------------------------------------------------------
module wwpc_datapath #(
    parameter int PATTERN_MAX = wwpc_pkg::PATTERN_MAX_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [wwpc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [wwpc_pkg::PAT_W-1:0]          cfg_wdata,
    input  logic [wwpc_pkg::BYTE_W-1:0]         in_byte,
    input  logic                                in_term,
    input  wwpc_pkg::dp_cmd_t                   cmd,
    output wwpc_pkg::dp_status_t                status,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [wwpc_pkg::BYTE_W-1:0]         m_tdata,
    output logic                                m_tlast
);
    import wwpc_pkg::*;

    localparam int IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int CNT_W  = $clog2(PATTERN_MAX + 1);
    localparam int ECNT_W = $clog2(PATTERN_MAX + 2);

    logic [PAT_W-1:0]   pattern_chars_reg;
    logic [LEN_W-1:0]   pattern_len_reg;

    logic [BYTE_W-1:0]  held_reg [PATTERN_MAX];
    logic [BYTE_W-1:0]  flush_buf_reg [PATTERN_MAX];
    logic [CNT_W-1:0]   hc_reg, hc_next;
    logic               mc_reg, mc_next;
    logic               before_na_reg, before_na_next;
    logic               last_na_reg, last_na_next;

    logic [CNT_W-1:0]   flush_n_reg, flush_n_next;
    logic               censor_reg, censor_next;
    logic [BYTE_W-1:0]  cur_byte_reg;
    logic [ECNT_W-1:0]  total_reg, total_next;
    logic [ECNT_W-1:0]  idx_reg;

    logic               m_tvalid_reg;
    logic [BYTE_W-1:0]  m_tdata_reg;
    logic               m_tlast_reg;

    logic [BYTE_W-1:0]  pat_bytes [PATTERN_MAX];
    logic [LEN_W-1:0]   len_clamped;
    logic [CNT_W-1:0]   len_eff;
    logic [IDX_W-1:0]   hc_idx;
    logic               cur_na;
    logic               hit_next;
    logic               hit_first;
    logic               emit_cur;
    logic               held_we;
    logic [IDX_W-1:0]   held_widx;
    logic [BYTE_W-1:0]  emit_byte;

    for (genvar g = 0; g < PATTERN_MAX; g++)
    begin : g_pat
        assign pat_bytes[g] = pattern_chars_reg[BYTE_W*g +: BYTE_W];
    end

    assign len_clamped = (pattern_len_reg > LEN_W'(PATTERN_MAX)) ?
                         LEN_W'(PATTERN_MAX) : pattern_len_reg;
    assign len_eff     = CNT_W'(len_clamped);
    assign hc_idx      = (hc_reg < CNT_W'(PATTERN_MAX)) ? hc_reg[IDX_W-1:0] : '0;
    assign cur_na      = in_term || !is_alnum(in_byte);
    assign hit_next    = (hc_reg < len_eff) && (hc_reg < CNT_W'(PATTERN_MAX)) &&
                         (fold_case(in_byte) == fold_case(pat_bytes[hc_idx]));
    assign hit_first   = (len_eff != '0) &&
                         (fold_case(in_byte) == fold_case(pat_bytes[0]));

    always_comb
    begin
        hc_next        = hc_reg;
        before_na_next = before_na_reg;
        flush_n_next   = '0;
        censor_next    = 1'b0;
        emit_cur       = 1'b0;
        held_we        = 1'b0;
        held_widx      = hc_idx;

        if (mc_reg)
        begin
            flush_n_next = hc_reg;
            censor_next  = before_na_reg && cur_na;
            hc_next      = '0;
        end
        else if (in_term || ((hc_reg != '0) && !hit_next))
        begin
            flush_n_next = hc_reg;
            hc_next      = '0;
        end
        else if (hc_reg != '0)
        begin
            held_we = 1'b1;
            hc_next = hc_reg + CNT_W'(1);
        end

        if (!in_term && (hc_next == '0))
        begin
            if (hit_first)
            begin
                held_we        = 1'b1;
                held_widx      = '0;
                before_na_next = last_na_reg;
                hc_next        = CNT_W'(1);
            end
            else
            begin
                emit_cur = 1'b1;
            end
        end

        mc_next      = (hc_next != '0) && (hc_next >= len_eff);
        last_na_next = cur_na;
        if (in_term)
        begin
            before_na_next = 1'b1;
            last_na_next   = 1'b1;
        end

        total_next = ECNT_W'(flush_n_next) + ECNT_W'(emit_cur);
    end

    assign emit_byte = (idx_reg < ECNT_W'(flush_n_reg)) ?
                       (censor_reg ? STAR_CHAR : flush_buf_reg[idx_reg[IDX_W-1:0]]) :
                       cur_byte_reg;

    assign status.empty    = (idx_reg == total_reg);
    assign status.last     = ((idx_reg + ECNT_W'(1)) == total_reg);
    assign status.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_chars_reg <= '0;
            pattern_len_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_PATTERN_CHARS: pattern_chars_reg <= cfg_wdata;
                REG_PATTERN_LEN:   pattern_len_reg   <= cfg_wdata[LEN_W-1:0];
                default:           pattern_len_reg   <= pattern_len_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg        <= '0;
            mc_reg        <= 1'b0;
            before_na_reg <= 1'b1;
            last_na_reg   <= 1'b1;
            flush_n_reg   <= '0;
            total_reg     <= '0;
            idx_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                hc_reg        <= hc_next;
                mc_reg        <= mc_next;
                before_na_reg <= before_na_next;
                last_na_reg   <= last_na_next;
                flush_n_reg   <= flush_n_next;
                total_reg     <= total_next;
                idx_reg       <= '0;
            end
            else if (cmd.advance)
            begin
                idx_reg <= idx_reg + ECNT_W'(1);
            end

            if (cmd.advance)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            censor_reg    <= censor_next;
            cur_byte_reg  <= in_byte;
            flush_buf_reg <= held_reg;
            if (held_we)
            begin
                held_reg[held_widx] <= in_byte;
            end
        end
        if (cmd.advance)
        begin
            m_tdata_reg <= emit_byte;
            m_tlast_reg <= status.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_hc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hc_reg <= CNT_W'(PATTERN_MAX))
        else $error("held count above pattern capacity");

    a_mc_holds: assert property (@(posedge clk) disable iff (!rst_n)
        mc_reg |-> (hc_reg != '0))
        else $error("complete match with no held bytes");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= total_reg)
        else $error("emit index past result count");

endmodule

/* rtl/core/wwpc_ctrl.sv */
// ----------------------------------------------------------------------------
// wwpc_ctrl
// Controller: takes one input transaction, then drains its results.
// ----------------------------------------------------------------------------
module wwpc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  wwpc_pkg::dp_status_t  status,
    output wwpc_pkg::dp_cmd_t     cmd
);
    import wwpc_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.empty || (status.out_free && status.last))
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready    = 1'b0;
        cmd.load    = 1'b0;
        cmd.advance = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_EMIT:
            begin
                cmd.advance = !status.empty && status.out_free;
            end
            default: s_tready = 1'b0;
        endcase
    end

    a_load_emits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_EMIT))
        else $error("load did not enter emit");

    a_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && status.empty) |=> (state_reg == ST_IDLE))
        else $error("drained item did not return to idle");

endmodule

/* rtl/core/whole_word_pattern_censor.sv */
// ----------------------------------------------------------------------------
// whole_word_pattern_censor
// Case-insensitive whole-word masking of a byte stream against a pattern.
// ----------------------------------------------------------------------------
// Flow: an accepted item is loaded into the match state, then its N results
//   (N <= PATTERN_MAX + 1) are sent through the output register; no new item
//   is accepted before they drain. One result byte leaves per cycle unless m_tready stalls.
// Reset: match state and context clear; pattern and length reset to zero,
//   so text passes unchanged until configured.
// ----------------------------------------------------------------------------
module whole_word_pattern_censor #(
    parameter int PATTERN_MAX = wwpc_pkg::PATTERN_MAX_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [wwpc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [wwpc_pkg::PAT_W-1:0]       cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [wwpc_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] text_byte
    input  logic                             s_tlast,   // is_terminator
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [wwpc_pkg::BYTE_W-1:0]      m_tdata,   // [7:0] out_byte
    output logic                             m_tlast    // run_last
);
    import wwpc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    wwpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wwpc_datapath #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_byte   (s_tdata),
        .in_term   (s_tlast),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

/* tb/whole_word_pattern_censor_tb.sv */
// ----------------------------------------------------------------------------
// whole_word_pattern_censor_tb
// Self-checking bench for the whole-word censor. A directed table covers
// pass-through after reset, byte extremes, censored and uncensored matches,
// retry after a mismatch, a length change during a partial match and an
// oversized length. Random phases follow, most writing a new pattern or
// length, with text built mostly from pattern words in mixed case, separators and
// noise. Every output transaction is checked against a local predictor or a
// fixed expected byte. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module whole_word_pattern_censor_tb;

    import wwpc_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 12;
    localparam int SETTLE       = 12;
    localparam int PAT_MAX      = 8;
    localparam int RANDOM_ITEMS = 185;

    typedef struct {
        logic [BYTE_W-1:0] ch;
        logic              last;
    } out_beat_t;

    typedef struct {
        bit                is_write;
        cfg_reg_t          addr;
        logic [PAT_W-1:0]  wdata;
        logic [BYTE_W-1:0] ch;
        bit                term;
        int                fixed_n;
        logic [BYTE_W-1:0] fixed_ch;
    } stim_row_t;

    typedef struct {
        logic [BYTE_W-1:0] ch;
        bit                term;
    } text_item_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [PAT_W-1:0]      cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [BYTE_W-1:0]     m_tdata;
    logic                  m_tlast;

    // predictor copy of the block state
    logic [PAT_W-1:0]  pat_chars;
    logic [LEN_W-1:0]  pat_len;
    logic [BYTE_W-1:0] held_buf [PAT_MAX];
    int unsigned       held_n;
    bit                match_done;
    bit                before_sep;
    bit                last_sep;

    logic [BYTE_W-1:0] step_chars [$];
    out_beat_t         pending_chars [$];
    stim_row_t         dir_rows [$];

    int  error_count;
    int  items_sent;
    bit  idle_on;

    whole_word_pattern_censor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    initial
    begin
        #(CLK_PERIOD * 400000);
        $display("** whole_word_pattern_censor: FAILED **");
        $finish;
    end

    function automatic bit is_word_char(logic [BYTE_W-1:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic [BYTE_W-1:0] to_lower(logic [BYTE_W-1:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic bit is_letter(logic [BYTE_W-1:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic int unsigned active_len();
        return (pat_len > PAT_MAX) ? PAT_MAX : pat_len;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    function automatic logic [BYTE_W-1:0] random_letter();
        logic [BYTE_W-1:0] c;
        c = 8'h61 + 8'($urandom_range(0, 25));
        if ($urandom_range(0, 1))
            c = c ^ 8'h20;
        return c;
    endfunction

    function automatic logic [PAT_W-1:0] random_pattern();
        logic [PAT_W-1:0] p;
        int               r;
        if ($urandom_range(0, 99) < 15)
            return {$urandom, $urandom};
        for (int i = 0; i < PAT_MAX; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                p[i*8 +: 8] = random_letter();
            else if (r < 80)
                p[i*8 +: 8] = 8'h30 + 8'($urandom_range(0, 9));
            else
                p[i*8 +: 8] = 8'($urandom_range(0, 255));
        end
        return p;
    endfunction

    function automatic stim_row_t item_row(logic [BYTE_W-1:0] ch, bit term, int fixed_n = -1,
                                           logic [BYTE_W-1:0] fixed_ch = 8'h00);
        stim_row_t row;
        row = '{is_write: 1'b0, addr: REG_PATTERN_CHARS, wdata: '0, ch: ch, term: term,
                fixed_n: fixed_n, fixed_ch: fixed_ch};
        return row;
    endfunction

    function automatic stim_row_t write_row(cfg_reg_t addr, logic [PAT_W-1:0] wdata);
        stim_row_t row;
        row = '{is_write: 1'b1, addr: addr, wdata: wdata, ch: 8'h00, term: 1'b0,
                fixed_n: -1, fixed_ch: 8'h00};
        return row;
    endfunction

    task automatic report_mismatch(string what, logic [BYTE_W-1:0] want,
                                   logic [BYTE_W-1:0] got);
        $display("[%0t] mismatch on %s: expected %02h, got %02h", $time, what, want, got);
        error_count++;
    endtask

    task automatic release_held(bit censor);
        for (int i = 0; i < held_n; i++)
            step_chars.push_back(censor ? STAR_CHAR : held_buf[i]);
        held_n     = 0;
        match_done = 1'b0;
    endtask

    task automatic predict_censor(logic [BYTE_W-1:0] b, bit term);
        bit          cur_sep;
        int unsigned len;
        cur_sep = term || !is_word_char(b);
        len     = active_len();
        step_chars.delete();
        if (match_done)
            release_held(before_sep && cur_sep);
        if (term)
        begin
            release_held(1'b0);
            before_sep = 1'b1;
            last_sep   = 1'b1;
        end
        else
        begin
            if (held_n > 0)
            begin
                if (held_n < len && to_lower(b) == to_lower(pat_chars[held_n*8 +: 8]))
                begin
                    held_buf[held_n] = b;
                    held_n++;
                end
                else
                    release_held(1'b0);
            end
            if (held_n == 0)
            begin
                if (len > 0 && to_lower(b) == to_lower(pat_chars[7:0]))
                begin
                    before_sep  = last_sep;
                    held_buf[0] = b;
                    held_n      = 1;
                end
                else
                    step_chars.push_back(b);
            end
            if (held_n > 0 && held_n >= len)
                match_done = 1'b1;
            last_sep = !is_word_char(b);
        end
    endtask

    task automatic queue_predicted();
        int n;
        n = step_chars.size();
        for (int i = 0; i < n; i++)
            pending_chars.push_back('{ch: step_chars[i], last: (i == n - 1)});
    endtask

    task automatic write_reg(cfg_reg_t addr, logic [PAT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        if (addr == REG_PATTERN_CHARS)
            pat_chars = value;
        else
            pat_len = value[LEN_W-1:0];
    endtask

    // hold the source until every expected byte is out and the block is quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_item(logic [BYTE_W-1:0] b, bit term);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= term;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        predict_censor(b, term);
    endtask

    // sink side: ready bursts broken by random stalls
    initial
    begin
        int gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_chars.size() == 0)
                report_mismatch("unexpected transaction", 8'h00, m_tdata);
            else
            begin
                want = pending_chars.pop_front();
                if (m_tdata !== want.ch)
                    report_mismatch("out_byte", want.ch, m_tdata);
                if (m_tlast !== want.last)
                    report_mismatch("run_last", 8'(want.last), 8'(m_tlast));
            end
        end
    end

    initial
    begin
        stim_row_t   row;
        text_item_t  text_q [$];
        bit          in_writes;
        int          r;
        int          phase_len;
        int          n;
        int unsigned len;
        logic [BYTE_W-1:0] c;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_addr    = '0;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        error_count = 0;
        items_sent  = 0;
        idle_on     = 1'b1;
        pat_chars   = '0;
        pat_len     = '0;
        held_n      = 0;
        match_done  = 1'b0;
        before_sep  = 1'b1;
        last_sep    = 1'b1;

        // after reset: length zero passes everything, empty terminator emits nothing
        dir_rows.push_back(item_row(8'h41, 1'b0, 1, 8'h41));
        dir_rows.push_back(item_row(8'h00, 1'b0, 1, 8'h00));
        dir_rows.push_back(item_row(8'hFF, 1'b0, 1, 8'hFF));
        dir_rows.push_back(item_row(8'h00, 1'b1, 0));
        // pattern "Cat"
        dir_rows.push_back(write_row(REG_PATTERN_CHARS, 64'h0000_0000_0074_6143));
        dir_rows.push_back(write_row(REG_PATTERN_LEN, 64'd3));
        dir_rows.push_back(item_row("c", 1'b0));
        dir_rows.push_back(item_row("A", 1'b0));
        dir_rows.push_back(item_row("t", 1'b0));
        dir_rows.push_back(item_row("!", 1'b0));
        // mismatch retries the current byte as a new start
        dir_rows.push_back(item_row("c", 1'b0));
        dir_rows.push_back(item_row("c", 1'b0));
        dir_rows.push_back(item_row("a", 1'b0));
        dir_rows.push_back(item_row("t", 1'b0));
        dir_rows.push_back(item_row(8'h00, 1'b1));
        // shrink the length under a partial match
        dir_rows.push_back(item_row("c", 1'b0));
        dir_rows.push_back(item_row("a", 1'b0));
        dir_rows.push_back(write_row(REG_PATTERN_LEN, 64'd2));
        dir_rows.push_back(item_row("x", 1'b0));
        // full-width pattern with zero and 0xFF bytes, oversized length
        dir_rows.push_back(write_row(REG_PATTERN_CHARS, 64'hFF7A_615A_4130_3900));
        dir_rows.push_back(write_row(REG_PATTERN_LEN, 64'd15));
        dir_rows.push_back(item_row(" ", 1'b0));
        dir_rows.push_back(item_row(8'h00, 1'b0));
        dir_rows.push_back(item_row("9", 1'b0));
        dir_rows.push_back(item_row("0", 1'b0));
        dir_rows.push_back(item_row("a", 1'b0));
        dir_rows.push_back(item_row("z", 1'b0));
        dir_rows.push_back(item_row("A", 1'b0));
        dir_rows.push_back(item_row("Z", 1'b0));
        dir_rows.push_back(item_row(8'hFF, 1'b0));
        dir_rows.push_back(item_row(8'h00, 1'b1));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        in_writes = 1'b0;
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.is_write)
            begin
                if (!in_writes)
                    settle();
                write_reg(row.addr, row.wdata);
                in_writes = 1'b1;
            end
            else
            begin
                if (in_writes)
                    cfg_we <= 1'b0;
                in_writes = 1'b0;
                send_item(row.ch, row.term);
                if (row.fixed_n == 1)
                    pending_chars.push_back('{ch: row.fixed_ch, last: 1'b1});
                else if (row.fixed_n < 0)
                    queue_predicted();
            end
        end

        items_sent = 0;
        for (int phase = 0; items_sent < RANDOM_ITEMS; phase++)
        begin
            settle();
            idle_on = (phase % 3) != 2;
            r = $urandom_range(0, 9);
            if (phase == 0 || r < 6)
                write_reg(REG_PATTERN_CHARS, random_pattern());
            if (r != 8)
            begin
                n = $urandom_range(0, 99);
                if (n < 10)
                    write_reg(REG_PATTERN_LEN, 64'd0);
                else if (n < 20)
                    write_reg(REG_PATTERN_LEN, 64'($urandom_range(9, 15)));
                else if (n < 30)
                    write_reg(REG_PATTERN_LEN, 64'd8);
                else
                    write_reg(REG_PATTERN_LEN, 64'($urandom_range(1, 4)));
            end
            cfg_we <= 1'b0;

            len       = active_len();
            phase_len = $urandom_range(15, 35);
            text_q.delete();
            while (text_q.size() < phase_len)
            begin
                r = $urandom_range(0, 99);
                if (r < 45 && len > 0)
                begin
                    n = $urandom_range(0, 99);
                    if (n < 15)
                        n = $urandom_range(1, len);
                    else
                        n = len;
                    for (int k = 0; k < n; k++)
                    begin
                        c = pat_chars[k*8 +: 8];
                        if (is_letter(c) && $urandom_range(0, 1))
                            c = c ^ 8'h20;
                        text_q.push_back('{ch: c, term: 1'b0});
                    end
                    if ($urandom_range(0, 99) < 15)
                        text_q.push_back('{ch: random_letter(), term: 1'b0});
                end
                else if (r < 70)
                begin
                    case ($urandom_range(0, 5))
                        0: c = " ";
                        1: c = ",";
                        2: c = ".";
                        3: c = "!";
                        4: c = 8'h0A;
                        default: c = 8'($urandom_range(128, 255));
                    endcase
                    text_q.push_back('{ch: c, term: 1'b0});
                end
                else if (r < 85)
                    text_q.push_back('{ch: random_letter(), term: 1'b0});
                else if (r < 95)
                    text_q.push_back('{ch: 8'($urandom_range(0, 255)), term: 1'b0});
                else
                    text_q.push_back('{ch: 8'($urandom_range(0, 255)), term: 1'b1});
            end
            if ($urandom_range(0, 1))
                text_q.push_back('{ch: 8'($urandom_range(0, 255)), term: 1'b1});

            foreach (text_q[k])
            begin
                send_item(text_q[k].ch, text_q[k].term);
                queue_predicted();
            end
        end

        s_tvalid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (4 * SETTLE) @(posedge clk);

        if (error_count == 0)
            $display("** whole_word_pattern_censor: PASSED **");
        else
            $display("** whole_word_pattern_censor: FAILED **");
        $finish;
    end

endmodule

/* whole_word_pattern_censor.f */
rtl/core/wwpc_pkg.sv
rtl/core/wwpc_datapath.sv
rtl/core/wwpc_ctrl.sv
rtl/core/whole_word_pattern_censor.sv
tb/whole_word_pattern_censor_tb.sv
